>>> src/arc_pkg.sv
// ----------------------------------------------------------------------------
// ARP resolver cache package
// Shared types, field widths and codes for the ARP resolver cache.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int FUNC_W   = 2;
  localparam int MAC_W    = 48;
  localparam int IP_W     = 32;
  localparam int HANDLE_W = 16;
  localparam int ET_W     = 16;
  localparam int OP_W     = 16;
  localparam int MS_W     = 32;
  localparam int TIME_W   = 20;
  localparam int KIND_W   = 3;
  localparam int CMP_W    = 32;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [FUNC_W-1:0] FUNC_SEND  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_IPV4    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DROP    = 3'd4;

  localparam logic [ET_W-1:0]  ET_IPV4        = 16'h0800;
  localparam logic [ET_W-1:0]  ET_ARP         = 16'h0806;
  localparam logic [OP_W-1:0]  ARP_OP_REQUEST = 16'd1;
  localparam logic [MAC_W-1:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY    = 8'd3;

  localparam logic [TIME_W-1:0] RST_LIFETIME = 20'd30000;
  localparam logic [TIME_W-1:0] RST_RETRY    = 20'd5000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEND_CACHE,
    ST_SEND_PEND,
    ST_SEND_DECIDE,
    ST_LEARN_SCAN,
    ST_LEARN_MIN,
    ST_LEARN_WRITE,
    ST_FLUSH_SCAN,
    ST_FLUSH_READ,
    ST_FLUSH_EMIT,
    ST_REPLY,
    ST_AGE_CACHE,
    ST_AGE_PEND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [MAC_W-1:0]    dst_mac;
    logic [IP_W-1:0]     target_ip;
    logic [HANDLE_W-1:0] handle;
  } result_t;

  typedef struct packed {
    logic             eq;
    logic             lt;
    logic [CMP_W-1:0] diff;
  } cmp_t;

endpackage

>>> src/arc_cmp_unit.sv
// ----------------------------------------------------------------------------
// ARP resolver cache compare unit
// Shared equality, less-than and subtract unit used by every table walk.
// ----------------------------------------------------------------------------
module arc_cmp_unit (
  input  logic [arc_pkg::CMP_W-1:0] a,
  input  logic [arc_pkg::CMP_W-1:0] b,
  output arc_pkg::cmp_t             res
);

  always_comb begin
    res.eq   = (a == b);
    res.lt   = (a < b);
    res.diff = a - b;
  end

endmodule

>>> src/arc_hmem.sv
// ----------------------------------------------------------------------------
// ARP resolver cache handle memory
// Queued datagram handles, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arc_hmem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [arc_pkg::HANDLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [arc_pkg::HANDLE_W-1:0] rd_data
);

  logic [arc_pkg::HANDLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/arp_resolver_cache.sv
// ----------------------------------------------------------------------------
// ARP resolver cache
// Resolves IPv4 next hops to MAC addresses with an aging cache and a table
// of unresolved addresses holding queued datagram handles.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one beat per send, received frame
// or time tick (func). in_stall is high from acceptance until the last
// result of that beat has been loaded into the output register.
// Output channel: out_valid/out_stall carry one result beat each; last marks
// the final result of an input beat. Inputs with no result give no beat.
// Config channel: cfg_valid/cfg_ready write register cfg_index with cfg_data;
// cfg_ready is always high. The user must make writes while the block is
// idle; the block itself does not enforce this.
// Timing: one entry of a table is visited per cycle by the shared compare
// unit, except that the tick walk of pending entries holds on an expiring
// entry until its result can be taken into the hold stage.
// A result is held in a one-deep stage before the output register, so a
// stalled receiver stops the walk only when a further result is produced.
// Reset clears all valid bits, the output register and the configuration
// (lifetime 30000 ms, retry 5000 ms); the block is ready on the next cycle.
// ----------------------------------------------------------------------------
module arp_resolver_cache #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 8,
  parameter int QUEUE_DEPTH     = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [arc_pkg::FUNC_W-1:0]     func,
  input  logic [arc_pkg::IP_W-1:0]       hop_ip,
  input  logic [arc_pkg::HANDLE_W-1:0]   datagram_handle,
  input  logic [arc_pkg::MAC_W-1:0]      frame_dst_mac,
  input  logic [arc_pkg::ET_W-1:0]       frame_ethertype,
  input  logic                           payload_ok,
  input  logic [arc_pkg::OP_W-1:0]       arp_opcode,
  input  logic [arc_pkg::MAC_W-1:0]      arp_sender_mac,
  input  logic [arc_pkg::IP_W-1:0]       arp_sender_ip,
  input  logic [arc_pkg::IP_W-1:0]       arp_target_ip,
  input  logic [arc_pkg::MS_W-1:0]       elapsed_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [arc_pkg::KIND_W-1:0]     kind,
  output logic [arc_pkg::MAC_W-1:0]      dst_mac,
  output logic [arc_pkg::IP_W-1:0]       target_ip,
  output logic [arc_pkg::HANDLE_W-1:0]   out_handle,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HDEPTH = PENDING_ENTRIES * QUEUE_DEPTH;
  localparam int AW = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

  // configuration
  logic [arc_pkg::MAC_W-1:0]  own_mac;
  logic [arc_pkg::IP_W-1:0]   own_ip;
  logic [arc_pkg::TIME_W-1:0] lifetime;
  logic [arc_pkg::TIME_W-1:0] retry;

  // captured input beat
  logic [arc_pkg::FUNC_W-1:0]   req_func;
  logic [arc_pkg::IP_W-1:0]     req_hop;
  logic [arc_pkg::HANDLE_W-1:0] req_handle;
  logic [arc_pkg::MAC_W-1:0]    req_fdst;
  logic [arc_pkg::ET_W-1:0]     req_etype;
  logic                         req_ok;
  logic [arc_pkg::OP_W-1:0]     req_opcode;
  logic [arc_pkg::MAC_W-1:0]    req_smac;
  logic [arc_pkg::IP_W-1:0]     req_sip;
  logic [arc_pkg::IP_W-1:0]     req_tip;
  logic [arc_pkg::MS_W-1:0]     req_elapsed;

  // tables
  logic [CACHE_ENTRIES-1:0]   cache_valid;
  logic [arc_pkg::IP_W-1:0]   cache_ip        [CACHE_ENTRIES];
  logic [arc_pkg::MAC_W-1:0]  cache_mac       [CACHE_ENTRIES];
  logic [arc_pkg::TIME_W-1:0] cache_time_left [CACHE_ENTRIES];

  logic [PENDING_ENTRIES-1:0] pending_valid;
  logic [arc_pkg::IP_W-1:0]   pending_ip        [PENDING_ENTRIES];
  logic [arc_pkg::TIME_W-1:0] pending_time_left [PENDING_ENTRIES];
  logic [QCW-1:0]             pending_count     [PENDING_ENTRIES];

  // sequencer
  arc_pkg::state_t state, state_next;
  logic [CIW-1:0]             cidx;
  logic [PIW-1:0]             pidx;
  logic [QCW-1:0]             qk;
  logic                       c_hit, c_free;
  logic [CIW-1:0]             c_hit_idx, c_free_idx, c_min_idx;
  logic [arc_pkg::TIME_W-1:0] c_min_t;
  logic                       p_hit, p_free;
  logic [PIW-1:0]             p_hit_idx, p_free_idx;

  logic             h_valid;
  arc_pkg::result_t h_res;

  logic [arc_pkg::CMP_W-1:0] cmp_a, cmp_b;
  arc_pkg::cmp_t             cmp;

  logic             emit_req, emit_ok, emit_fire, push_mid, push_end, can_push;
  arc_pkg::result_t emit_res;

  logic c_last, p_last, c_hit_now, c_free_now, p_hit_now, p_free_now;
  logic for_us, age_expire, want_reply, flush_more;

  logic                         hm_wr_en, hm_rd_en;
  logic [AW-1:0]                hm_wr_addr, hm_rd_addr;
  logic [arc_pkg::HANDLE_W-1:0] hm_rd_data;

  arc_cmp_unit u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  arc_hmem #(
    .DEPTH (HDEPTH),
    .AW    (AW)
  ) u_hmem (
    .clk     (clk),
    .wr_en   (hm_wr_en),
    .wr_addr (hm_wr_addr),
    .wr_data (req_handle),
    .rd_en   (hm_rd_en),
    .rd_addr (hm_rd_addr),
    .rd_data (hm_rd_data)
  );

  assign in_stall  = (state != arc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign can_push  = !out_valid || !out_stall;

  assign c_last     = (cidx == CIW'(CACHE_ENTRIES - 1));
  assign p_last     = (pidx == PIW'(PENDING_ENTRIES - 1));
  assign c_hit_now  = cache_valid[cidx] && cmp.eq;
  assign c_free_now = !cache_valid[cidx];
  assign p_hit_now  = pending_valid[pidx] && cmp.eq;
  assign p_free_now = !pending_valid[pidx];
  assign for_us     = ((req_fdst == own_mac) || (req_fdst == arc_pkg::BCAST_MAC)) && req_ok;
  assign age_expire = pending_valid[pidx] && (cmp.lt || cmp.eq);
  assign want_reply = (req_opcode == arc_pkg::ARP_OP_REQUEST) && cmp.eq;
  assign flush_more = ((qk + QCW'(1)) < pending_count[p_hit_idx]);

  assign emit_ok   = !h_valid || can_push;
  assign emit_fire = emit_req && emit_ok;
  assign push_mid  = emit_fire && h_valid;
  assign push_end  = (state == arc_pkg::ST_FINISH) && h_valid && can_push;

  assign hm_rd_en   = (state == arc_pkg::ST_FLUSH_READ);
  assign hm_rd_addr = AW'(p_hit_idx) * AW'(QUEUE_DEPTH) + AW'(qk);

  always_comb begin
    hm_wr_en   = 1'b0;
    hm_wr_addr = AW'(p_free_idx) * AW'(QUEUE_DEPTH);
    if (state == arc_pkg::ST_SEND_DECIDE) begin
      if (p_hit) begin
        hm_wr_en   = (pending_count[p_hit_idx] < QCW'(QUEUE_DEPTH));
        hm_wr_addr = AW'(p_hit_idx) * AW'(QUEUE_DEPTH) + AW'(pending_count[p_hit_idx]);
      end else begin
        hm_wr_en = p_free;
      end
    end
  end

  // compare operand select
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      arc_pkg::ST_SEND_CACHE: begin
        cmp_a = cache_ip[cidx];
        cmp_b = req_hop;
      end
      arc_pkg::ST_LEARN_SCAN: begin
        cmp_a = cache_ip[cidx];
        cmp_b = req_sip;
      end
      arc_pkg::ST_LEARN_MIN: begin
        cmp_a = arc_pkg::CMP_W'(cache_time_left[cidx]);
        cmp_b = arc_pkg::CMP_W'(c_min_t);
      end
      arc_pkg::ST_SEND_PEND: begin
        cmp_a = pending_ip[pidx];
        cmp_b = req_hop;
      end
      arc_pkg::ST_FLUSH_SCAN: begin
        cmp_a = pending_ip[pidx];
        cmp_b = req_sip;
      end
      arc_pkg::ST_REPLY: begin
        cmp_a = req_tip;
        cmp_b = own_ip;
      end
      arc_pkg::ST_AGE_CACHE: begin
        cmp_a = arc_pkg::CMP_W'(cache_time_left[cidx]);
        cmp_b = req_elapsed;
      end
      arc_pkg::ST_AGE_PEND: begin
        cmp_a = arc_pkg::CMP_W'(pending_time_left[pidx]);
        cmp_b = req_elapsed;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      arc_pkg::ST_IDLE: begin
        if (in_valid) state_next = arc_pkg::ST_DECODE;
      end
      arc_pkg::ST_DECODE: begin
        case (req_func)
          arc_pkg::FUNC_SEND: state_next = arc_pkg::ST_SEND_CACHE;
          arc_pkg::FUNC_FRAME: begin
            if (for_us && req_etype == arc_pkg::ET_ARP) state_next = arc_pkg::ST_LEARN_SCAN;
            else state_next = arc_pkg::ST_FINISH;
          end
          arc_pkg::FUNC_TICK: state_next = arc_pkg::ST_AGE_CACHE;
          default: state_next = arc_pkg::ST_FINISH;
        endcase
      end
      arc_pkg::ST_SEND_CACHE: begin
        if (c_hit_now) state_next = arc_pkg::ST_FINISH;
        else if (c_last) state_next = arc_pkg::ST_SEND_PEND;
      end
      arc_pkg::ST_SEND_PEND: begin
        if (p_last) state_next = arc_pkg::ST_SEND_DECIDE;
      end
      arc_pkg::ST_SEND_DECIDE: state_next = arc_pkg::ST_FINISH;
      arc_pkg::ST_LEARN_SCAN: begin
        if (c_last) begin
          if (c_hit || c_free || c_hit_now || c_free_now) state_next = arc_pkg::ST_LEARN_WRITE;
          else state_next = arc_pkg::ST_LEARN_MIN;
        end
      end
      arc_pkg::ST_LEARN_MIN: begin
        if (c_last) state_next = arc_pkg::ST_LEARN_WRITE;
      end
      arc_pkg::ST_LEARN_WRITE: state_next = arc_pkg::ST_FLUSH_SCAN;
      arc_pkg::ST_FLUSH_SCAN: begin
        if (p_last) begin
          if (p_hit || p_hit_now) state_next = arc_pkg::ST_FLUSH_READ;
          else state_next = arc_pkg::ST_REPLY;
        end
      end
      arc_pkg::ST_FLUSH_READ: state_next = arc_pkg::ST_FLUSH_EMIT;
      arc_pkg::ST_FLUSH_EMIT: begin
        if (emit_ok) begin
          if (flush_more) state_next = arc_pkg::ST_FLUSH_READ;
          else state_next = arc_pkg::ST_REPLY;
        end
      end
      arc_pkg::ST_REPLY: begin
        if (!want_reply || emit_ok) state_next = arc_pkg::ST_FINISH;
      end
      arc_pkg::ST_AGE_CACHE: begin
        if (c_last) state_next = arc_pkg::ST_AGE_PEND;
      end
      arc_pkg::ST_AGE_PEND: begin
        if (p_last && (!age_expire || emit_ok)) state_next = arc_pkg::ST_FINISH;
      end
      arc_pkg::ST_FINISH: begin
        if (!h_valid || can_push) state_next = arc_pkg::ST_IDLE;
      end
      default: state_next = arc_pkg::ST_IDLE;
    endcase
  end

  // result generation
  always_comb begin
    emit_req           = 1'b0;
    emit_res.kind      = arc_pkg::KIND_DROP;
    emit_res.dst_mac   = '0;
    emit_res.target_ip = '0;
    emit_res.handle    = req_handle;
    case (state)
      arc_pkg::ST_DECODE: begin
        if (req_func == arc_pkg::FUNC_FRAME && for_us && req_etype == arc_pkg::ET_IPV4) begin
          emit_req      = 1'b1;
          emit_res.kind = arc_pkg::KIND_DELIVER;
        end
      end
      arc_pkg::ST_SEND_CACHE: begin
        if (c_hit_now) begin
          emit_req         = 1'b1;
          emit_res.kind    = arc_pkg::KIND_IPV4;
          emit_res.dst_mac = cache_mac[cidx];
        end
      end
      arc_pkg::ST_SEND_DECIDE: begin
        if (p_hit) begin
          emit_req = !(pending_count[p_hit_idx] < QCW'(QUEUE_DEPTH));
        end else if (p_free) begin
          emit_req           = 1'b1;
          emit_res.kind      = arc_pkg::KIND_REQUEST;
          emit_res.dst_mac   = arc_pkg::BCAST_MAC;
          emit_res.target_ip = req_hop;
          emit_res.handle    = '0;
        end else begin
          emit_req = 1'b1;
        end
      end
      arc_pkg::ST_FLUSH_EMIT: begin
        emit_req         = 1'b1;
        emit_res.kind    = arc_pkg::KIND_IPV4;
        emit_res.dst_mac = req_smac;
        emit_res.handle  = hm_rd_data;
      end
      arc_pkg::ST_REPLY: begin
        emit_req           = want_reply;
        emit_res.kind      = arc_pkg::KIND_REPLY;
        emit_res.dst_mac   = req_smac;
        emit_res.target_ip = req_sip;
        emit_res.handle    = '0;
      end
      arc_pkg::ST_AGE_PEND: begin
        emit_req           = age_expire;
        emit_res.kind      = arc_pkg::KIND_REQUEST;
        emit_res.dst_mac   = arc_pkg::BCAST_MAC;
        emit_res.target_ip = pending_ip[pidx];
        emit_res.handle    = '0;
      end
      default: emit_req = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac  <= '0;
      own_ip   <= '0;
      lifetime <= arc_pkg::RST_LIFETIME;
      retry    <= arc_pkg::RST_RETRY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arc_pkg::CFG_OWN_MAC:  own_mac  <= cfg_data;
        arc_pkg::CFG_OWN_IP:   own_ip   <= cfg_data[arc_pkg::IP_W-1:0];
        arc_pkg::CFG_LIFETIME: lifetime <= cfg_data[arc_pkg::TIME_W-1:0];
        arc_pkg::CFG_RETRY:    retry    <= cfg_data[arc_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // capture input beat
  always_ff @(posedge clk) begin
    if (state == arc_pkg::ST_IDLE && in_valid) begin
      req_func    <= func;
      req_hop     <= hop_ip;
      req_handle  <= datagram_handle;
      req_fdst    <= frame_dst_mac;
      req_etype   <= frame_ethertype;
      req_ok      <= payload_ok;
      req_opcode  <= arp_opcode;
      req_smac    <= arp_sender_mac;
      req_sip     <= arp_sender_ip;
      req_tip     <= arp_target_ip;
      req_elapsed <= elapsed_ms;
    end
  end

  // walk counters and scan results
  always_ff @(posedge clk) begin
    if (rst) begin
      cidx   <= '0;
      pidx   <= '0;
      qk     <= '0;
      c_hit  <= 1'b0;
      c_free <= 1'b0;
      p_hit  <= 1'b0;
      p_free <= 1'b0;
    end else begin
      case (state)
        arc_pkg::ST_IDLE: begin
          cidx   <= '0;
          pidx   <= '0;
          qk     <= '0;
          c_hit  <= 1'b0;
          c_free <= 1'b0;
          p_hit  <= 1'b0;
          p_free <= 1'b0;
        end
        arc_pkg::ST_SEND_CACHE, arc_pkg::ST_AGE_CACHE: begin
          cidx <= c_last ? '0 : cidx + CIW'(1);
        end
        arc_pkg::ST_LEARN_SCAN: begin
          if (c_hit_now && !c_hit) begin
            c_hit     <= 1'b1;
            c_hit_idx <= cidx;
          end
          if (c_free_now && !c_free) begin
            c_free     <= 1'b1;
            c_free_idx <= cidx;
          end
          cidx <= c_last ? '0 : cidx + CIW'(1);
        end
        arc_pkg::ST_LEARN_MIN: begin
          if (cidx == '0 || cmp.lt) begin
            c_min_idx <= cidx;
            c_min_t   <= cache_time_left[cidx];
          end
          cidx <= c_last ? '0 : cidx + CIW'(1);
        end
        arc_pkg::ST_SEND_PEND, arc_pkg::ST_FLUSH_SCAN: begin
          if (p_hit_now && !p_hit) begin
            p_hit     <= 1'b1;
            p_hit_idx <= pidx;
          end
          if (p_free_now && !p_free) begin
            p_free     <= 1'b1;
            p_free_idx <= pidx;
          end
          pidx <= p_last ? '0 : pidx + PIW'(1);
        end
        arc_pkg::ST_FLUSH_EMIT: begin
          if (emit_ok) qk <= qk + QCW'(1);
        end
        arc_pkg::ST_AGE_PEND: begin
          if (!age_expire || emit_ok) pidx <= p_last ? '0 : pidx + PIW'(1);
        end
        default: ;
      endcase
    end
  end

  // cache valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_valid <= '0;
    end else if (state == arc_pkg::ST_LEARN_WRITE) begin
      if (c_hit) cache_valid[c_hit_idx] <= 1'b1;
      else if (c_free) cache_valid[c_free_idx] <= 1'b1;
      else cache_valid[c_min_idx] <= 1'b1;
    end else if (state == arc_pkg::ST_AGE_CACHE) begin
      if (cache_valid[cidx] && (cmp.lt || cmp.eq)) cache_valid[cidx] <= 1'b0;
    end
  end

  // cache payload
  always_ff @(posedge clk) begin
    if (state == arc_pkg::ST_LEARN_WRITE) begin
      if (c_hit) begin
        cache_ip[c_hit_idx]        <= req_sip;
        cache_mac[c_hit_idx]       <= req_smac;
        cache_time_left[c_hit_idx] <= lifetime;
      end else if (c_free) begin
        cache_ip[c_free_idx]        <= req_sip;
        cache_mac[c_free_idx]       <= req_smac;
        cache_time_left[c_free_idx] <= lifetime;
      end else begin
        cache_ip[c_min_idx]        <= req_sip;
        cache_mac[c_min_idx]       <= req_smac;
        cache_time_left[c_min_idx] <= lifetime;
      end
    end else if (state == arc_pkg::ST_AGE_CACHE) begin
      if (cache_valid[cidx] && !(cmp.lt || cmp.eq)) begin
        cache_time_left[cidx] <= cmp.diff[arc_pkg::TIME_W-1:0];
      end
    end
  end

  // pending valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= '0;
    end else if (state == arc_pkg::ST_SEND_DECIDE) begin
      if (!p_hit && p_free) pending_valid[p_free_idx] <= 1'b1;
    end else if (state == arc_pkg::ST_FLUSH_EMIT) begin
      if (emit_ok && !flush_more) pending_valid[p_hit_idx] <= 1'b0;
    end
  end

  // pending payload
  always_ff @(posedge clk) begin
    case (state)
      arc_pkg::ST_SEND_DECIDE: begin
        if (p_hit) begin
          if (pending_count[p_hit_idx] < QCW'(QUEUE_DEPTH)) begin
            pending_count[p_hit_idx] <= pending_count[p_hit_idx] + QCW'(1);
          end
        end else if (p_free) begin
          pending_ip[p_free_idx]        <= req_hop;
          pending_time_left[p_free_idx] <= retry;
          pending_count[p_free_idx]     <= QCW'(1);
        end
      end
      arc_pkg::ST_FLUSH_EMIT: begin
        if (emit_ok && !flush_more) pending_count[p_hit_idx] <= '0;
      end
      arc_pkg::ST_AGE_PEND: begin
        if (pending_valid[pidx]) begin
          if (cmp.lt || cmp.eq) begin
            if (emit_ok) pending_time_left[pidx] <= retry;
          end else begin
            pending_time_left[pidx] <= cmp.diff[arc_pkg::TIME_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // hold stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (emit_fire) begin
      h_valid <= 1'b1;
    end else if (push_end) begin
      h_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) h_res <= emit_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_end) begin
      kind       <= h_res.kind;
      dst_mac    <= h_res.dst_mac;
      target_ip  <= h_res.target_ip;
      out_handle <= h_res.handle;
      last       <= push_end;
    end
  end

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    (state == arc_pkg::ST_IDLE) |-> !h_valid)
    else $error("result left in hold stage at idle");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == arc_pkg::ST_DECODE))
    else $error("accepted beat not decoded");

  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == arc_pkg::ST_FLUSH_EMIT) |-> (qk < pending_count[p_hit_idx]))
    else $error("flush beyond queue fill");

endmodule
